### rtl/kmhc_pkg.sv
package kmhc_pkg;

    localparam int MAX_K       = 7;
    localparam int WIN_W       = 2 * MAX_K;
    localparam int TABLE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 16;
    localparam int LEN_W       = 3;
    localparam int FUNC_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int QUERY_W     = 14;

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = LEN_W'(MAX_K);
    localparam logic [LEN_W-1:0] LEN_MAX        = LEN_W'(MAX_K);

    // decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G = 8'h47;
    localparam logic [BYTE_W-1:0] CH_T = 8'h54;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_SEQ   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INC,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RMW
    } t_back_state;

endpackage

### rtl/kmer_histogram_counter_top.sv
// K-mer histogram over a DNA byte stream. Words carry func (0 clear, 1 sequence byte,
// 2 query, 3 ignored); bytes other than uppercase A/C/G/T are dropped. The front end
// takes one word per cycle while its four-entry op queue has room and keeps the rolling
// window itself; the back end owns the 16384 x 16 count table (single-port RAM with a
// registered read) and takes one counted base or query at a time, through IDLE (table
// read) and RMW (write-back, or result into the output holding register once free).
// A clear, and reset, start a clearing pass over the whole table, one entry per cycle;
// words still queue up to four deep meanwhile, then o_ready drops until the pass ends.
module kmer_histogram_counter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kmhc_pkg::LEN_W-1:0]      i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [kmhc_pkg::FUNC_W-1:0]     i_func,
    input  logic [kmhc_pkg::BYTE_W-1:0]     i_seq_byte,
    input  logic [kmhc_pkg::QUERY_W-1:0]    i_query_code,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kmhc_pkg::COUNT_W-1:0]    o_kmer_count
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    kmhc_pkg::t_op  q_in_op;
    kmhc_pkg::t_op  q_out_op;

    kmhc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_seq_byte   (i_seq_byte),
        .i_query_code (i_query_code),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_op       (q_in_op)
    );

    kmhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (q_out_op)
    );

    kmhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_op       (q_out_op),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kmer_count (o_kmer_count)
    );

endmodule

### rtl/kmhc_front.sv
module kmhc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kmhc_pkg::LEN_W-1:0]     i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [kmhc_pkg::FUNC_W-1:0]    i_func,
    input  logic [kmhc_pkg::BYTE_W-1:0]    i_seq_byte,
    input  logic [kmhc_pkg::QUERY_W-1:0]   i_query_code,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output kmhc_pkg::t_op                  o_q_op
);

    logic [kmhc_pkg::LEN_W-1:0]  r_kmer_len;
    logic [kmhc_pkg::WIN_W-1:0]  r_window;
    logic [kmhc_pkg::WIN_W-1:0]  n_window;
    logic [kmhc_pkg::LEN_W-1:0]  r_bases;
    logic [kmhc_pkg::LEN_W-1:0]  n_bases;

    logic                        accept;
    logic [kmhc_pkg::LEN_W-1:0]  eff_len;
    logic [1:0]                  base;
    logic                        base_ok;
    logic [kmhc_pkg::WIN_W-1:0]  win_shift;
    logic [kmhc_pkg::LEN_W-1:0]  bases_inc;
    logic [kmhc_pkg::WIN_W-1:0]  len_mask;
    kmhc_pkg::t_func             func;

    assign func    = kmhc_pkg::t_func'(i_func);
    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        if (r_kmer_len == '0) begin
            eff_len = kmhc_pkg::LEN_W'(1);
        end else if (r_kmer_len > kmhc_pkg::LEN_MAX) begin
            eff_len = kmhc_pkg::LEN_MAX;
        end else begin
            eff_len = r_kmer_len;
        end
    end

    always_comb begin
        base_ok = 1'b1;
        case (i_seq_byte)
            kmhc_pkg::CH_A: base = 2'd0;
            kmhc_pkg::CH_C: base = 2'd1;
            kmhc_pkg::CH_G: base = 2'd2;
            kmhc_pkg::CH_T: base = 2'd3;
            default: begin
                base    = 2'd0;
                base_ok = 1'b0;
            end
        endcase
    end

    assign win_shift = {r_window[kmhc_pkg::WIN_W-3:0], base};
    assign bases_inc = (r_bases < kmhc_pkg::LEN_MAX) ? r_bases + 1'b1 : r_bases;
    // keep the newest eff_len bases
    assign len_mask  = ~({kmhc_pkg::WIN_W{1'b1}} << {eff_len, 1'b0});

    always_comb begin
        n_window     = r_window;
        n_bases      = r_bases;
        o_q_push     = 1'b0;
        o_q_op.kind  = kmhc_pkg::OP_READ;
        o_q_op.addr  = kmhc_pkg::ADDR_W'(i_query_code);
        if (accept) begin
            unique case (func)
                kmhc_pkg::FUNC_CLEAR: begin
                    n_window    = '0;
                    n_bases     = '0;
                    o_q_push    = 1'b1;
                    o_q_op.kind = kmhc_pkg::OP_CLEAR;
                end
                kmhc_pkg::FUNC_SEQ: begin
                    if (base_ok) begin
                        n_window    = win_shift;
                        n_bases     = bases_inc;
                        o_q_push    = (bases_inc >= eff_len);
                        o_q_op.kind = kmhc_pkg::OP_INC;
                        o_q_op.addr = kmhc_pkg::ADDR_W'(win_shift & len_mask);
                    end
                end
                kmhc_pkg::FUNC_QUERY: begin
                    o_q_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= kmhc_pkg::KMER_LEN_RESET;
            r_window   <= '0;
            r_bases    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end
            r_window <= n_window;
            r_bases  <= n_bases;
        end
    end

endmodule

### rtl/kmhc_queue.sv
module kmhc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kmhc_pkg::t_op   i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output kmhc_pkg::t_op   o_op
);

    kmhc_pkg::t_op                  r_slot [kmhc_pkg::Q_DEPTH];
    logic [kmhc_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [kmhc_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [kmhc_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == kmhc_pkg::Q_CNT_W'(kmhc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/kmhc_back.sv
module kmhc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  kmhc_pkg::t_op                   i_q_op,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kmhc_pkg::COUNT_W-1:0]    o_kmer_count
);

    logic [kmhc_pkg::COUNT_W-1:0] mem [kmhc_pkg::TABLE_DEPTH];

    kmhc_pkg::t_back_state          r_state;
    kmhc_pkg::t_back_state          n_state;
    logic [kmhc_pkg::ADDR_W-1:0]    r_clr_addr;
    logic [kmhc_pkg::ADDR_W-1:0]    n_clr_addr;
    kmhc_pkg::t_op_kind             r_kind;
    kmhc_pkg::t_op_kind             n_kind;
    logic [kmhc_pkg::ADDR_W-1:0]    r_addr;
    logic [kmhc_pkg::ADDR_W-1:0]    n_addr;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [kmhc_pkg::COUNT_W-1:0]   r_out_count;
    logic [kmhc_pkg::COUNT_W-1:0]   r_rdata;

    logic                           mem_re;
    logic                           mem_we;
    logic [kmhc_pkg::ADDR_W-1:0]    mem_waddr;
    logic [kmhc_pkg::COUNT_W-1:0]   mem_wdata;
    logic                           out_load;
    logic                           out_free;
    logic [kmhc_pkg::COUNT_W-1:0]   count_inc;

    assign o_valid      = r_out_valid;
    assign o_kmer_count = r_out_count;
    assign out_free     = !r_out_valid || i_ready;
    // saturating increment
    assign count_inc    = (&r_rdata) ? r_rdata : r_rdata + 1'b1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[i_q_op.addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_kind      = r_kind;
        n_addr      = r_addr;
        o_q_pop     = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = count_inc;
        out_load    = 1'b0;
        unique case (r_state)
            kmhc_pkg::BK_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == kmhc_pkg::ADDR_W'(kmhc_pkg::TABLE_DEPTH - 1)) begin
                    n_state = kmhc_pkg::BK_IDLE;
                end
            end
            kmhc_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_q_op.kind;
                    n_addr  = i_q_op.addr;
                    if (i_q_op.kind == kmhc_pkg::OP_CLEAR) begin
                        n_clr_addr = '0;
                        n_state    = kmhc_pkg::BK_CLEAR;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = kmhc_pkg::BK_RMW;
                    end
                end
            end
            kmhc_pkg::BK_RMW: begin
                // read word is in r_rdata; it holds while the output stalls
                if (r_kind == kmhc_pkg::OP_INC) begin
                    mem_we  = 1'b1;
                    n_state = kmhc_pkg::BK_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = kmhc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = kmhc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= r_rdata;
        end
        r_kind <= n_kind;
        r_addr <= n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmhc_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
